/* rtl/bilrs_pkg.sv */
// shared constants, types and helper functions of the bilinear rgb scaler
package bilrs_pkg;

  localparam int MAX_SOURCE_SIDE = 128;
  localparam int MAX_TARGET_SIDE = 1024;

  localparam int SRC_CFG_W  = 8;
  localparam int TGT_CFG_W  = 11;
  localparam int CFG_DATA_W = TGT_CFG_W;
  localparam int CFG_IDX_W  = 2;

  localparam int SRC_W       = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int SRC_IDX_W   = $clog2(MAX_SOURCE_SIDE);
  localparam int TGT_W       = $clog2(MAX_TARGET_SIDE + 1);
  localparam int TGT_IDX_W   = $clog2(MAX_TARGET_SIDE);
  localparam int STORE_DEPTH = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int FRAC_W  = 16;
  localparam int STEP_W  = SRC_W + FRAC_W;
  localparam int POS_W   = TGT_IDX_W + STEP_W;
  localparam int CRD_W   = POS_W - FRAC_W;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int PIX_W   = CH_W * NUM_CH;
  localparam int WGT_W   = 2 * (FRAC_W + 1);
  localparam int ACC_W   = CH_W + WGT_W;
  localparam int DIV_CNT_W = $clog2(STEP_W + 1);

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_reg_t;

  // neighbours of the source point: a (x,y), b (x+1,y), c (x,y+1), d (x+1,y+1)
  typedef enum logic [1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2,
    CORNER_D = 2'd3
  } corner_t;

  typedef struct packed {
    logic    issue;
    logic    first;
    corner_t corner;
  } blend_ctl_t;

  function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_CFG_W-1:0] v);
    logic [SRC_W-1:0] r;
    if (v == '0) begin
      r = SRC_W'(1);
    end else if (32'(v) > 32'(MAX_SOURCE_SIDE)) begin
      r = SRC_W'(MAX_SOURCE_SIDE);
    end else begin
      r = SRC_W'(v);
    end
    return r;
  endfunction

  function automatic logic [TGT_W-1:0] clamp_tgt(input logic [TGT_CFG_W-1:0] v);
    logic [TGT_W-1:0] r;
    if (v == '0) begin
      r = TGT_W'(1);
    end else if (32'(v) > 32'(MAX_TARGET_SIDE)) begin
      r = TGT_W'(MAX_TARGET_SIDE);
    end else begin
      r = TGT_W'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/bilinear_rgb_image_scaler_unit.sv */
// top level of the bilinear rgb888 frame scaler: sequencer, counters, config
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata red,green,blue; tuser operation
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata red,green,blue; tlast frame end
//  cfg      in   cfg_we (no wait)               cfg_index, cfg_data
//
// a load word is taken from idle and writes the frame store straight away
// a request word keeps the block busy until its result is loaded into the output register:
// one read at the last source row or column and four reads for an interior point (all on
// the one frame store port), and no new word is taken until then; the first request of a
// frame also waits for the two 24-step divisions of the source step
// rst is synchronous: counters cleared, size registers back to 128, store undefined
// a result waiting on m_axis_tready holds the next request in the finish state, which also holds off loads
module bilinear_rgb_image_scaler_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bilrs_pkg::PIX_W-1:0]       s_axis_tdata,  // red_in, green_in, blue_in
  input  logic [0:0]                        s_axis_tuser,  // operation
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bilrs_pkg::PIX_W-1:0]       m_axis_tdata,  // red_out, green_out, blue_out
  output logic                              m_axis_tlast,  // frame_end
  input  logic                              cfg_we,
  input  logic [bilrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bilrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV_H = 8'b0000_0010,
    S_DIV_V = 8'b0000_0100,
    S_POS   = 8'b0000_1000,
    S_ADDR  = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_MAC   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // size registers, raw and as used
  logic [bilrs_pkg::SRC_CFG_W-1:0] source_width;
  logic [bilrs_pkg::SRC_CFG_W-1:0] source_height;
  logic [bilrs_pkg::TGT_CFG_W-1:0] target_width;
  logic [bilrs_pkg::TGT_CFG_W-1:0] target_height;
  logic [bilrs_pkg::SRC_W-1:0]     sw;
  logic [bilrs_pkg::SRC_W-1:0]     sh;
  logic [bilrs_pkg::TGT_W-1:0]     tw;
  logic [bilrs_pkg::TGT_W-1:0]     th;
  logic [bilrs_pkg::SRC_W-1:0]     sw_m1;
  logic [bilrs_pkg::SRC_W-1:0]     sh_m1;

  // frame state
  logic [bilrs_pkg::ADDR_W-1:0]    load_pointer;
  logic [bilrs_pkg::ADDR_W:0]      lp_inc;
  logic [2*bilrs_pkg::SRC_W-1:0]   frame_px;
  logic [bilrs_pkg::TGT_IDX_W-1:0] col;
  logic [bilrs_pkg::TGT_IDX_W-1:0] row;
  logic [bilrs_pkg::STEP_W-1:0]    step_h;
  logic [bilrs_pkg::STEP_W-1:0]    step_v;
  logic                            steps_ready;

  // per-request datapath
  logic [bilrs_pkg::POS_W-1:0]     pos_x;
  logic [bilrs_pkg::POS_W-1:0]     pos_y;
  logic [bilrs_pkg::CRD_W-1:0]     sx_raw;
  logic [bilrs_pkg::CRD_W-1:0]     sy_raw;
  logic [bilrs_pkg::SRC_IDX_W-1:0] sx;
  logic [bilrs_pkg::SRC_IDX_W-1:0] sy;
  logic [bilrs_pkg::SRC_IDX_W+bilrs_pkg::SRC_W-1:0] row_off;
  logic                            interior_c;
  logic                            interior;
  logic [bilrs_pkg::ADDR_W-1:0]    base;
  logic [bilrs_pkg::FRAC_W-1:0]    fx;
  logic [bilrs_pkg::FRAC_W-1:0]    fy;
  bilrs_pkg::corner_t              corner;
  logic                            read_last;
  logic [bilrs_pkg::ADDR_W-1:0]    rd_addr;

  // handshakes and unit hookups
  logic                            in_acc;
  logic                            load_acc;
  logic                            req_acc;
  logic                            out_load;
  logic                            col_last;
  logic                            row_last;
  logic                            frame_last;
  logic                            div_start;
  logic                            div_done;
  logic [bilrs_pkg::STEP_W-1:0]    div_num;
  logic [bilrs_pkg::TGT_W-1:0]     div_den;
  logic [bilrs_pkg::STEP_W-1:0]    div_quot;
  logic                            ram_we;
  logic [bilrs_pkg::ADDR_W-1:0]    ram_addr;
  logic [bilrs_pkg::PIX_W-1:0]     ram_rdata;
  bilrs_pkg::blend_ctl_t           blend_ctl;
  logic [bilrs_pkg::PIX_W-1:0]     blend_pixel;

  // ---------------------------------------------------------------------------
  // configuration registers, zero and oversize values clamped on use
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= bilrs_pkg::SRC_CFG_W'(128);
      source_height <= bilrs_pkg::SRC_CFG_W'(128);
      target_width  <= bilrs_pkg::TGT_CFG_W'(128);
      target_height <= bilrs_pkg::TGT_CFG_W'(128);
    end else if (cfg_we) begin
      case (bilrs_pkg::cfg_reg_t'(cfg_index))
        bilrs_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[bilrs_pkg::SRC_CFG_W-1:0];
        bilrs_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[bilrs_pkg::SRC_CFG_W-1:0];
        bilrs_pkg::REG_TARGET_WIDTH:  target_width  <= cfg_data[bilrs_pkg::TGT_CFG_W-1:0];
        bilrs_pkg::REG_TARGET_HEIGHT: target_height <= cfg_data[bilrs_pkg::TGT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign sw    = bilrs_pkg::clamp_src(source_width);
  assign sh    = bilrs_pkg::clamp_src(source_height);
  assign tw    = bilrs_pkg::clamp_tgt(target_width);
  assign th    = bilrs_pkg::clamp_tgt(target_height);
  assign sw_m1 = sw - 1'b1;
  assign sh_m1 = sh - 1'b1;

  // ---------------------------------------------------------------------------
  // input handshake: one word at a time, only from idle
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign load_acc = in_acc && (bilrs_pkg::op_t'(s_axis_tuser) == bilrs_pkg::OP_LOAD);
  assign req_acc  = in_acc && (bilrs_pkg::op_t'(s_axis_tuser) == bilrs_pkg::OP_REQUEST);

  // load pointer wraps at the end of the source frame
  assign lp_inc   = {1'b0, load_pointer} + 1'b1;
  assign frame_px = sw * sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
    end else if (load_acc) begin
      if (32'(lp_inc) >= 32'(frame_px)) begin
        load_pointer <= '0;
      end else begin
        load_pointer <= lp_inc[bilrs_pkg::ADDR_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          state_next = steps_ready ? S_POS : S_DIV_H;
        end
      end
      S_DIV_H: begin
        if (div_done) begin
          state_next = S_DIV_V;
        end
      end
      S_DIV_V: begin
        if (div_done) begin
          state_next = S_POS;
        end
      end
      S_POS:  state_next = S_ADDR;
      S_ADDR: state_next = S_READ;
      S_READ: begin
        if (read_last) begin
          state_next = S_MAC;
        end
      end
      S_MAC:  state_next = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // source step: horizontal then vertical through the shared divider
  // ---------------------------------------------------------------------------
  assign div_start = (req_acc && !steps_ready) || (state == S_DIV_H && div_done);
  assign div_num   = (state == S_IDLE) ? {sw, {bilrs_pkg::FRAC_W{1'b0}}}
                                       : {sh, {bilrs_pkg::FRAC_W{1'b0}}};
  assign div_den   = (state == S_IDLE) ? tw : th;

  bilrs_step_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // source point: position products, then clamp, fractions and base address
  // ---------------------------------------------------------------------------
  assign sx_raw = pos_x[bilrs_pkg::POS_W-1:bilrs_pkg::FRAC_W];
  assign sy_raw = pos_y[bilrs_pkg::POS_W-1:bilrs_pkg::FRAC_W];
  assign sx = (32'(sx_raw) > 32'(sw_m1)) ? sw_m1[bilrs_pkg::SRC_IDX_W-1:0]
                                         : sx_raw[bilrs_pkg::SRC_IDX_W-1:0];
  assign sy = (32'(sy_raw) > 32'(sh_m1)) ? sh_m1[bilrs_pkg::SRC_IDX_W-1:0]
                                         : sy_raw[bilrs_pkg::SRC_IDX_W-1:0];
  assign interior_c = (32'(sx_raw) < 32'(sw_m1)) && (32'(sy_raw) < 32'(sh_m1));
  assign row_off    = sy * sw;

  // neighbour addresses stay inside the frame for an interior point
  always_comb begin
    case (corner)
      bilrs_pkg::CORNER_A: rd_addr = base;
      bilrs_pkg::CORNER_B: rd_addr = base + 1'b1;
      bilrs_pkg::CORNER_C: rd_addr = bilrs_pkg::ADDR_W'(base + sw);
      bilrs_pkg::CORNER_D: rd_addr = bilrs_pkg::ADDR_W'(base + sw + 1'b1);
      default:             rd_addr = base;
    endcase
  end

  // edge pixels are a plain copy: one read with full weight on a
  assign read_last = interior ? (corner == bilrs_pkg::CORNER_D)
                              : (corner == bilrs_pkg::CORNER_A);

  always_ff @(posedge clk) begin
    if (state == S_POS) begin
      pos_x <= bilrs_pkg::POS_W'(col) * bilrs_pkg::POS_W'(step_h);
      pos_y <= bilrs_pkg::POS_W'(row) * bilrs_pkg::POS_W'(step_v);
    end
    if (state == S_ADDR) begin
      base     <= bilrs_pkg::ADDR_W'(row_off + (bilrs_pkg::SRC_IDX_W + bilrs_pkg::SRC_W)'(sx));
      interior <= interior_c;
      fx       <= interior_c ? pos_x[bilrs_pkg::FRAC_W-1:0] : '0;
      fy       <= interior_c ? pos_y[bilrs_pkg::FRAC_W-1:0] : '0;
      corner   <= bilrs_pkg::CORNER_A;
    end else if (state == S_READ) begin
      corner <= bilrs_pkg::corner_t'(corner + 2'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // frame store: loads only from idle, reads only in the read state
  // ---------------------------------------------------------------------------
  assign ram_we   = load_acc;
  assign ram_addr = load_acc ? load_pointer : rd_addr;

  bilrs_ram u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s_axis_tdata),
    .rdata (ram_rdata)
  );

  assign blend_ctl.issue  = (state == S_READ);
  assign blend_ctl.first  = (corner == bilrs_pkg::CORNER_A);
  assign blend_ctl.corner = corner;

  bilrs_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .ctl   (blend_ctl),
    .fx    (fx),
    .fy    (fy),
    .rdata (ram_rdata),
    .pixel (blend_pixel)
  );

  // ---------------------------------------------------------------------------
  // output register, raster counters and step lifetime
  // ---------------------------------------------------------------------------
  assign out_load   = (state == S_FIN) && (!m_axis_tvalid || m_axis_tready);
  assign col_last   = (32'(col) >= 32'(tw) - 32'd1);
  assign row_last   = (32'(row) >= 32'(th) - 32'd1);
  assign frame_last = col_last && row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      col           <= '0;
      row           <= '0;
      steps_ready   <= 1'b0;
      step_h        <= '0;
      step_v        <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (state == S_DIV_H && div_done) begin
        step_h <= div_quot;
      end
      if (state == S_DIV_V && div_done) begin
        step_v      <= div_quot;
        steps_ready <= 1'b1;
      end

      if (out_load) begin
        if (col_last) begin
          col <= '0;
          if (row_last) begin
            row         <= '0;
            steps_ready <= 1'b0;
          end else begin
            row <= row + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= blend_pixel;
      m_axis_tlast <= frame_last;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_corner_interior: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && corner != bilrs_pkg::CORNER_A) |-> interior)
    else $error("neighbour read for a point on the last row or column");

  a_pos_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_POS) |-> steps_ready)
    else $error("position computed before the source step is known");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_H || state == S_DIV_V))
    else $error("divider finished outside a division state");

  a_frame_rearm: assert property (@(posedge clk) disable iff (rst)
    (out_load && frame_last) |=> !steps_ready)
    else $error("source step kept past the end of the frame");

endmodule

/* rtl/bilrs_ram.sv */
// single-port synchronous frame store ram, read data registered
module bilrs_ram #(
  parameter int DEPTH = bilrs_pkg::STORE_DEPTH,
  parameter int WIDTH = bilrs_pkg::PIX_W,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/bilrs_step_div.sv */
// iterative restoring divider for the q8.16 source step, one quotient bit per cycle
module bilrs_step_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bilrs_pkg::STEP_W-1:0]  num,
  input  logic [bilrs_pkg::TGT_W-1:0]   den,
  output logic                          done,
  output logic [bilrs_pkg::STEP_W-1:0]  quot
);

  logic                            busy;
  logic [bilrs_pkg::DIV_CNT_W-1:0] cnt;
  logic [bilrs_pkg::TGT_W-1:0]     rem;
  logic [bilrs_pkg::TGT_W-1:0]     den_r;
  logic [bilrs_pkg::TGT_W:0]       trial;
  logic                            fits;

  assign trial = {rem, quot[bilrs_pkg::STEP_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bilrs_pkg::DIV_CNT_W'(bilrs_pkg::STEP_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == bilrs_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload: remainder, shifting dividend/quotient, latched divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (busy) begin
      rem  <= fits ? bilrs_pkg::TGT_W'(trial - {1'b0, den_r})
                   : trial[bilrs_pkg::TGT_W-1:0];
      quot <= {quot[bilrs_pkg::STEP_W-2:0], fits};
    end
  end

endmodule

/* rtl/bilrs_blend.sv */
// weight multiplier and per-channel multiply-accumulate over the neighbour reads
module bilrs_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  bilrs_pkg::blend_ctl_t         ctl,
  input  logic [bilrs_pkg::FRAC_W-1:0]  fx,
  input  logic [bilrs_pkg::FRAC_W-1:0]  fy,
  input  logic [bilrs_pkg::PIX_W-1:0]   rdata,
  output logic [bilrs_pkg::PIX_W-1:0]   pixel
);

  localparam logic [bilrs_pkg::FRAC_W:0] ONE = {1'b1, {bilrs_pkg::FRAC_W{1'b0}}};

  logic [bilrs_pkg::FRAC_W:0]  gx;
  logic [bilrs_pkg::FRAC_W:0]  gy;
  logic [bilrs_pkg::FRAC_W:0]  opx;
  logic [bilrs_pkg::FRAC_W:0]  opy;
  logic [bilrs_pkg::WGT_W-1:0] wgt;
  logic                        mac_en;
  logic                        first_d;
  logic [bilrs_pkg::ACC_W-1:0] acc [bilrs_pkg::NUM_CH];

  assign gx = ONE - {1'b0, fx};
  assign gy = ONE - {1'b0, fy};

  always_comb begin
    case (ctl.corner)
      bilrs_pkg::CORNER_A: begin
        opx = gx;
        opy = gy;
      end
      bilrs_pkg::CORNER_B: begin
        opx = {1'b0, fx};
        opy = gy;
      end
      bilrs_pkg::CORNER_C: begin
        opx = gx;
        opy = {1'b0, fy};
      end
      bilrs_pkg::CORNER_D: begin
        opx = {1'b0, fx};
        opy = {1'b0, fy};
      end
      default: begin
        opx = gx;
        opy = gy;
      end
    endcase
  end

  // weight is registered so that it lines up with the registered ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_en <= 1'b0;
    end else begin
      mac_en <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    wgt     <= opx * opy;
    first_d <= ctl.first;
    if (mac_en) begin
      for (int k = 0; k < bilrs_pkg::NUM_CH; k++) begin
        acc[k] <= (first_d ? '0 : acc[k]) +
                  bilrs_pkg::ACC_W'(rdata[k*bilrs_pkg::CH_W +: bilrs_pkg::CH_W]) *
                  bilrs_pkg::ACC_W'(wgt);
      end
    end
  end

  // sum truncated by dropping the 2*frac_w weight bits
  always_comb begin
    for (int k = 0; k < bilrs_pkg::NUM_CH; k++) begin
      pixel[k*bilrs_pkg::CH_W +: bilrs_pkg::CH_W] =
        acc[k][2*bilrs_pkg::FRAC_W +: bilrs_pkg::CH_W];
    end
  end

endmodule

/* dv/bilinear_rgb_image_scaler_checker.sv */
`timescale 1ns / 100ps
// stream checker for the bilinear rgb scaler: predicts each output pixel and compares
module bilinear_rgb_image_scaler_checker
  import bilrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // red_in, green_in, blue_in
  input  logic [0:0]            s_axis_tuser,   // operation
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [PIX_W-1:0]      m_axis_tdata,   // red_out, green_out, blue_out
  input  logic                  m_axis_tlast,   // frame_end
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    failures,
  output int                    outstanding
);

  // red sits in the low byte, as on the stream
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef struct {
    rgb_t px;
    logic frame_end;
  } scaled_word_t;

  rgb_t                src_frame [STORE_DEPTH];
  scaled_word_t        expected_pixels [$];
  logic [SRC_CFG_W-1:0] src_w_reg, src_h_reg;
  logic [TGT_CFG_W-1:0] tgt_w_reg, tgt_h_reg;
  int unsigned         load_ptr, out_row, out_col, step_x, step_y;
  bit                  steps_valid;

  function automatic int unsigned side_of(input int unsigned v, input int unsigned limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : v;
  endfunction

  // four-tap weighted sum in q.32, truncated
  function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] a, b, c, d,
                                            input longint unsigned fx, fy);
    longint unsigned gx, gy, acc;
    gx  = (64'd1 << FRAC_W) - fx;
    gy  = (64'd1 << FRAC_W) - fy;
    acc = a * gx * gy + b * fx * gy + c * gx * fy + d * fx * fy;
    return CH_W'(acc >> (2 * FRAC_W));
  endfunction

  function automatic scaled_word_t next_scaled_pixel();
    int unsigned     sw, sh, tw, th, sx, sy, base;
    longint unsigned pos_x, pos_y, fx, fy;
    rgb_t            a, b, c, d;
    scaled_word_t    w;
    sw = side_of(src_w_reg, MAX_SOURCE_SIDE);
    sh = side_of(src_h_reg, MAX_SOURCE_SIDE);
    tw = side_of(tgt_w_reg, MAX_TARGET_SIDE);
    th = side_of(tgt_h_reg, MAX_TARGET_SIDE);
    // steps are latched on the first pixel of a frame
    if (!steps_valid) begin
      step_x      = (sw << FRAC_W) / tw;
      step_y      = (sh << FRAC_W) / th;
      steps_valid = 1'b1;
    end
    pos_x = 64'(out_col) * 64'(step_x);
    pos_y = 64'(out_row) * 64'(step_y);
    sx    = 32'(pos_x >> FRAC_W);
    sy    = 32'(pos_y >> FRAC_W);
    fx    = pos_x & 64'hFFFF;
    fy    = pos_y & 64'hFFFF;
    if (sx > sw - 1) sx = sw - 1;
    if (sy > sh - 1) sy = sh - 1;
    base = sy * sw + sx;
    a    = src_frame[base];
    if (sx < sw - 1 && sy < sh - 1) begin
      b = src_frame[base + 1];
      c = src_frame[base + sw];
      d = src_frame[base + sw + 1];
      w.px.red   = blend(a.red, b.red, c.red, d.red, fx, fy);
      w.px.green = blend(a.green, b.green, c.green, d.green, fx, fy);
      w.px.blue  = blend(a.blue, b.blue, c.blue, d.blue, fx, fy);
    end else begin
      w.px = a;
    end
    w.frame_end = 1'b0;
    if (out_col >= tw - 1) begin
      out_col = 0;
      if (out_row >= th - 1) begin
        out_row     = 0;
        steps_valid = 1'b0;
        w.frame_end = 1'b1;
      end else begin
        out_row++;
      end
    end else begin
      out_col++;
    end
    return w;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      failures++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    scaled_word_t want;
    rgb_t         got;
    if (rst) begin
      src_w_reg   = SRC_CFG_W'(128);
      src_h_reg   = SRC_CFG_W'(128);
      tgt_w_reg   = TGT_CFG_W'(128);
      tgt_h_reg   = TGT_CFG_W'(128);
      load_ptr    = 0;
      out_row     = 0;
      out_col     = 0;
      step_x      = 0;
      step_y      = 0;
      steps_valid = 1'b0;
      expected_pixels.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          failures++;
          $error("output word with no pixel expected");
        end else begin
          want = expected_pixels.pop_front();
          got  = rgb_t'(m_axis_tdata);
          check_field("red_out", want.px.red, got.red);
          check_field("green_out", want.px.green, got.green);
          check_field("blue_out", want.px.blue, got.blue);
          check_field("frame_end", want.frame_end, m_axis_tlast);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SOURCE_WIDTH:  src_w_reg = cfg_data[SRC_CFG_W-1:0];
          REG_SOURCE_HEIGHT: src_h_reg = cfg_data[SRC_CFG_W-1:0];
          REG_TARGET_WIDTH:  tgt_w_reg = cfg_data[TGT_CFG_W-1:0];
          REG_TARGET_HEIGHT: tgt_h_reg = cfg_data[TGT_CFG_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (op_t'(s_axis_tuser) == OP_REQUEST) begin
          expected_pixels.push_back(next_scaled_pixel());
        end else begin
          if (load_ptr < STORE_DEPTH) src_frame[load_ptr] = rgb_t'(s_axis_tdata);
          load_ptr++;
          if (load_ptr >= side_of(src_w_reg, MAX_SOURCE_SIDE) *
                          side_of(src_h_reg, MAX_SOURCE_SIDE)) load_ptr = 0;
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

/* dv/bilinear_rgb_image_scaler_unit_tb.sv */
`timescale 1ns / 100ps
// testbench top for the bilinear rgb scaler: stimulus, idling, timeout and verdict
module bilinear_rgb_image_scaler_unit_tb;
  import bilrs_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ITEM_TARGET   = 1200;
  localparam int QUIET_TAIL    = 150;   // last words go with no idling on either side
  localparam int SETTLE_CYCLES = 100;   // covers a request in flight plus the step division
  localparam int BIG_AREA      = 256;   // cap on loads per source frame
  localparam int FILL_FRAME    = -1;    // load count meaning: load until the pointer wraps
  localparam int SIZE_AT_RESET = 128;

  localparam logic [3:0] SOURCE_REGS = (4'd1 << REG_SOURCE_WIDTH) | (4'd1 << REG_SOURCE_HEIGHT);
  localparam logic [3:0] TARGET_REGS = (4'd1 << REG_TARGET_WIDTH) | (4'd1 << REG_TARGET_HEIGHT);
  localparam logic [3:0] ALL_REGS    = SOURCE_REGS | TARGET_REGS;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;   // red_in, green_in, blue_in
  logic [0:0]            s_axis_tuser;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;   // red_out, green_out, blue_out
  logic                  m_axis_tlast;   // frame_end
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int failures;
  int outstanding;

  // shadow of the size registers and load pointer, only to keep requests
  // away from frame store entries that were never written
  logic [SRC_CFG_W-1:0] src_w_raw = SRC_CFG_W'(SIZE_AT_RESET);
  logic [SRC_CFG_W-1:0] src_h_raw = SRC_CFG_W'(SIZE_AT_RESET);
  logic [TGT_CFG_W-1:0] tgt_w_raw = TGT_CFG_W'(SIZE_AT_RESET);
  logic [TGT_CFG_W-1:0] tgt_h_raw = TGT_CFG_W'(SIZE_AT_RESET);
  int unsigned load_ptr;
  int unsigned loaded_extent;   // entries 0 .. loaded_extent-1 hold loaded pixels

  int loads_sent, requests_sent, frames_seen, settings_done;
  int idle_level;   // 0 = no idling, 1..3 = growing density of idle bursts
  int stall_left;
  int cycle_count;

  bilinear_rgb_image_scaler_unit dut (.*);

  bilinear_rgb_image_scaler_checker chk (.*);

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // output side: random stall bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (idle_level > 0 && $urandom_range(0, 9) < idle_level) begin
      m_axis_tready = 1'b0;
      stall_left    = $urandom_range(0, 12);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // watchdog and frame count
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && m_axis_tvalid && m_axis_tready && m_axis_tlast) frames_seen++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic int unsigned effective_side(input int unsigned v, input int unsigned limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : v;
  endfunction

  function automatic int unsigned src_area();
    return effective_side(src_w_raw, MAX_SOURCE_SIDE) * effective_side(src_h_raw, MAX_SOURCE_SIDE);
  endfunction

  // mostly random pixels, with all-zero and all-ones channels now and then
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_source_side();
    case ($urandom_range(0, 23))
      0: return '0;
      // the maximum, or an oversized value that acts as it
      1: return ($urandom_range(0, 1) == 0) ? CFG_DATA_W'(MAX_SOURCE_SIDE)
                                             : CFG_DATA_W'($urandom_range(MAX_SOURCE_SIDE + 1, 255));
      // stray bits above the 8-bit register are dropped
      2: return {3'($urandom_range(1, 7)), 8'($urandom_range(1, 6))};
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_target_side();
    case ($urandom_range(0, 23))
      0: return '0;
      1: return CFG_DATA_W'(MAX_TARGET_SIDE);
      2: return CFG_DATA_W'($urandom_range(MAX_TARGET_SIDE + 1, 2047));
      3: return CFG_DATA_W'($urandom_range(9, 40));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SOURCE_WIDTH:  src_w_raw = value[SRC_CFG_W-1:0];
      REG_SOURCE_HEIGHT: src_h_raw = value[SRC_CFG_W-1:0];
      REG_TARGET_WIDTH:  tgt_w_raw = value[TGT_CFG_W-1:0];
      REG_TARGET_HEIGHT: tgt_h_raw = value[TGT_CFG_W-1:0];
      default: ;
    endcase
  endtask

  // one word on the input stream; entered and left at a falling edge
  task automatic send_word(input op_t op, input logic [PIX_W-1:0] pix);
    if (idle_level > 0 && $urandom_range(0, 9) < idle_level) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = pix;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (op == OP_LOAD) begin
      loads_sent++;
      if (load_ptr + 1 > loaded_extent) loaded_extent = load_ptr + 1;
      load_ptr++;
      if (load_ptr >= src_area()) load_ptr = 0;
    end else begin
      requests_sent++;
    end
  endtask

  // drop valid and wait until every predicted pixel is out and the block is quiet
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // size writes while idle, then loads with early requests mixed in, then requests;
  // requests are only sent once the whole source area has been written at least once
  task automatic run_phase(input logic [3:0] mask,
                           input logic [CFG_DATA_W-1:0] sw_v, sh_v, tw_v, th_v,
                           input int n_early, input int n_loads, input int n_requests);
    int early_left, load_left;
    settle();
    if (mask[REG_SOURCE_WIDTH])  write_reg(REG_SOURCE_WIDTH, sw_v);
    if (mask[REG_SOURCE_HEIGHT]) write_reg(REG_SOURCE_HEIGHT, sh_v);
    if (mask[REG_TARGET_WIDTH])  write_reg(REG_TARGET_WIDTH, tw_v);
    if (mask[REG_TARGET_HEIGHT]) write_reg(REG_TARGET_HEIGHT, th_v);
    if (mask != '0) settings_done++;
    if (n_loads == FILL_FRAME) begin
      n_loads = (load_ptr >= src_area()) ? 1 : src_area() - load_ptr;
    end
    early_left = (loaded_extent >= src_area()) ? n_early : 0;
    load_left  = n_loads;
    while (early_left + load_left > 0) begin
      if ($urandom_range(1, early_left + load_left) <= early_left) begin
        send_word(OP_REQUEST, PIX_W'($urandom));
        early_left--;
      end else begin
        send_word(OP_LOAD, rand_pixel());
        load_left--;
      end
    end
    if (loaded_extent >= src_area()) begin
      repeat (n_requests) send_word(OP_REQUEST, PIX_W'($urandom));
    end
  endtask

  initial begin
    logic [3:0]            mask;
    logic [CFG_DATA_W-1:0] sw_v, sh_v, tw_v, th_v;
    int unsigned           sw_next, sh_next, tw_next, th_next, frame_px;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    cfg_we        = 1'b0;
    cfg_index     = REG_SOURCE_WIDTH;
    cfg_data      = '0;
    idle_level    = 2;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 2x2 source with black, white and random pixels, read back with the
    // reset-time 128x128 target: interior blends from the very first pixel
    run_phase(SOURCE_REGS, 2, 2, 0, 0, 0, 0, 0);
    send_word(OP_LOAD, '0);
    send_word(OP_LOAD, '1);
    send_word(OP_LOAD, rand_pixel());
    send_word(OP_LOAD, PIX_W'($urandom));
    repeat (3) send_word(OP_REQUEST, PIX_W'($urandom));

    // shrink the target mid-frame to 3x3: the row wraps at once, steps stay
    // until the frame ends, then the next frame computes new ones
    run_phase(TARGET_REGS, 0, 0, 3, 3, 0, 0, 9);

    // zero width acts as one, oversized target height acts as the maximum;
    // one request to the old store is mixed in among the loads of the new frame
    run_phase(ALL_REGS, 0, 3, 0, 2047, 1, FILL_FRAME, 3);

    // height down to one mid-frame: the next pixel closes the frame
    run_phase(4'd1 << REG_TARGET_HEIGHT, 0, 0, 0, 1, 0, 0, 1);

    // random phases: mostly whole frames loaded then read back, some noise
    while (loads_sent + requests_sent < ITEM_TARGET) begin
      mask = 4'($urandom_range(0, 15));
      sw_v = pick_source_side();
      sh_v = pick_source_side();
      tw_v = pick_target_side();
      th_v = pick_target_side();
      sw_next = effective_side(mask[REG_SOURCE_WIDTH] ? sw_v[SRC_CFG_W-1:0] : src_w_raw,
                               MAX_SOURCE_SIDE);
      sh_next = effective_side(mask[REG_SOURCE_HEIGHT] ? sh_v[SRC_CFG_W-1:0] : src_h_raw,
                               MAX_SOURCE_SIDE);
      tw_next = effective_side(mask[REG_TARGET_WIDTH] ? tw_v : CFG_DATA_W'(tgt_w_raw),
                               MAX_TARGET_SIDE);
      th_next = effective_side(mask[REG_TARGET_HEIGHT] ? th_v : CFG_DATA_W'(tgt_h_raw),
                               MAX_TARGET_SIDE);
      // keep one long side thin so a frame never needs thousands of loads
      if (sw_next * sh_next > BIG_AREA) begin
        if (sw_next >= sh_next) begin
          sh_v = CFG_DATA_W'($urandom_range(1, 2));
          mask[REG_SOURCE_HEIGHT] = 1'b1;
        end else begin
          sw_v = CFG_DATA_W'($urandom_range(1, 2));
          mask[REG_SOURCE_WIDTH] = 1'b1;
        end
      end
      frame_px   = tw_next * th_next;
      idle_level = (loads_sent + requests_sent > ITEM_TARGET - QUIET_TAIL) ? 0 :
                   $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 7) begin
        // large targets only get a slice; a later size write ends that frame
        run_phase(mask, sw_v, sh_v, tw_v, th_v,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0, FILL_FRAME,
                  $urandom_range(1, (frame_px < 60) ? frame_px + 3 : 60));
      end else begin
        run_phase(mask, sw_v, sh_v, tw_v, th_v,
                  $urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 4));
      end
    end

    idle_level = 0;
    settle();
    $display("loaded %0d source pixels, requested %0d output pixels over %0d size settings",
             loads_sent, requests_sent, settings_done);
    $display("%0d frames ran through their last pixel", frames_seen);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
